// ===== src/nie_pkg.sv =====
package nie_pkg;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EXTRAP = 2'd1;
    localparam logic [1:0] ST_FEW    = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef enum logic [1:0] {
        ALU_DIV = 2'b01,
        ALU_MUL = 2'b10
    } alu_op_t;

    typedef struct packed {
        logic               go;
        alu_op_t            op;
        logic signed [32:0] a;
        logic signed [32:0] b;
        logic signed [31:0] c;
    } alu_req_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] value;
    } alu_rsp_t;

endpackage

// ===== src/newton_interpolation_engine.sv =====
// Insert: shifts equal and larger nodes up one slot each, then writes the new node.
// Query: end checks and binary search over the node RAM read port, window load,
// then n(n+1)/2 divides and n multiplies, all on one serial divide/multiply unit.
// One item at a time: busy stays high until the done strobe; the receiver cannot
// stall. Reset empties the node table; node storage itself is not cleared.
module newton_interpolation_engine #(
    parameter int TABLE_DEPTH = 32,
    parameter int MAX_DEGREE  = 7
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               op,
    input  logic signed [31:0] node_arg,
    input  logic signed [31:0] node_value,
    input  logic signed [31:0] query_point,
    input  logic [2:0]         degree,
    output logic               done,
    output logic signed [31:0] result_value,
    output logic [1:0]         status
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int DW = $clog2(MAX_DEGREE + 1);
    localparam int NE = MAX_DEGREE + 1;

    typedef enum logic [16:0] {
        S_IDLE     = 17'h00001,
        S_INS_RD   = 17'h00002,
        S_INS_CMP  = 17'h00004,
        S_INS_PUT  = 17'h00008,
        S_Q_FIRST  = 17'h00010,
        S_Q_FIRSTW = 17'h00020,
        S_Q_LAST   = 17'h00040,
        S_Q_LASTW  = 17'h00080,
        S_BS       = 17'h00100,
        S_BSW      = 17'h00200,
        S_LD_RD    = 17'h00400,
        S_LD_W     = 17'h00800,
        S_DD       = 17'h01000,
        S_DD_WAIT  = 17'h02000,
        S_HN       = 17'h04000,
        S_HN_WAIT  = 17'h08000,
        S_SPARE    = 17'h10000
    } state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      hi_reg, hi_next;
    logic [AW-1:0]      start_reg, start_next;
    logic [DW-1:0]      j_reg, j_next;
    logic [DW-1:0]      i_reg, i_next;
    logic [DW-1:0]      k_reg, k_next;
    logic [DW-1:0]      n_reg, n_next;
    logic signed [31:0] x_reg, x_next;
    logic signed [31:0] a_reg, a_next;
    logic signed [31:0] v_reg, v_next;
    logic signed [31:0] p_reg, p_next;
    logic [1:0]         qstat_reg, qstat_next;
    logic signed [31:0] coef_reg [NE];
    logic signed [31:0] coef_next [NE];
    logic signed [31:0] xs_reg [NE];
    logic signed [31:0] xs_next [NE];
    logic               done_reg, done_next;
    logic signed [31:0] result_reg, result_next;
    logic [1:0]         status_reg, status_next;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [63:0]        ram_wdata, ram_rdata;
    logic signed [31:0] rd_arg, rd_val;

    nie_pkg::alu_req_t  alu_req;
    nie_pkg::alu_rsp_t  alu_rsp;

    int                 n_int, mid_int, s_int;

    nie_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    nie_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .rsp   (alu_rsp)
    );

    assign rd_arg = ram_rdata[63:32];
    assign rd_val = ram_rdata[31:0];

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        hi_next     = hi_reg;
        start_next  = start_reg;
        j_next      = j_reg;
        i_next      = i_reg;
        k_next      = k_reg;
        n_next      = n_reg;
        x_next      = x_reg;
        a_next      = a_reg;
        v_next      = v_reg;
        p_next      = p_reg;
        qstat_next  = qstat_reg;
        coef_next   = coef_reg;
        xs_next     = xs_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        status_next = status_reg;
        ram_we      = 1'b0;
        ram_waddr   = idx_reg[AW-1:0];
        ram_wdata   = ram_rdata;
        ram_raddr   = '0;
        alu_req     = '{go: 1'b0, op: nie_pkg::ALU_DIV, a: '0, b: '0, c: '0};
        n_int       = (int'(degree) > MAX_DEGREE) ? MAX_DEGREE : int'(degree);
        mid_int     = (int'(idx_reg) + int'(hi_reg)) / 2;
        s_int       = 0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    a_next = node_arg;
                    v_next = node_value;
                    x_next = query_point;
                    n_next = DW'(n_int);
                    if (!op)
                    begin
                        if (int'(count_reg) >= TABLE_DEPTH)
                        begin
                            done_next   = 1'b1;
                            result_next = '0;
                            status_next = nie_pkg::ST_FULL;
                        end
                        else
                        begin
                            idx_next   = count_reg;
                            state_next = S_INS_RD;
                        end
                    end
                    else if (int'(count_reg) < n_int + 1)
                    begin
                        done_next   = 1'b1;
                        result_next = '0;
                        status_next = nie_pkg::ST_FEW;
                    end
                    else
                    begin
                        state_next = S_Q_FIRST;
                    end
                end
            end

            S_INS_RD:
            begin
                ram_raddr = AW'(idx_reg - CW'(1));
                state_next = (idx_reg == '0) ? S_INS_PUT : S_INS_CMP;
            end

            S_INS_CMP:
            begin
                // shift equal and larger keys up one slot
                if (rd_arg >= a_reg)
                begin
                    ram_we     = 1'b1;
                    idx_next   = idx_reg - CW'(1);
                    state_next = S_INS_RD;
                end
                else
                begin
                    state_next = S_INS_PUT;
                end
            end

            S_INS_PUT:
            begin
                ram_we      = 1'b1;
                ram_wdata   = {a_reg, v_reg};
                count_next  = count_reg + CW'(1);
                done_next   = 1'b1;
                result_next = '0;
                status_next = nie_pkg::ST_OK;
                state_next  = S_IDLE;
            end

            S_Q_FIRST:
            begin
                ram_raddr  = '0;
                state_next = S_Q_FIRSTW;
            end

            S_Q_FIRSTW:
            begin
                j_next = '0;
                if (x_reg <= rd_arg)
                begin
                    start_next = '0;
                    qstat_next = nie_pkg::ST_EXTRAP;
                    state_next = S_LD_RD;
                end
                else
                begin
                    state_next = S_Q_LAST;
                end
            end

            S_Q_LAST:
            begin
                ram_raddr  = AW'(count_reg - CW'(1));
                state_next = S_Q_LASTW;
            end

            S_Q_LASTW:
            begin
                if (x_reg >= rd_arg)
                begin
                    start_next = AW'(int'(count_reg) - int'(n_reg) - 1);
                    qstat_next = nie_pkg::ST_EXTRAP;
                    state_next = S_LD_RD;
                end
                else
                begin
                    idx_next   = '0;
                    hi_next    = count_reg - CW'(1);
                    qstat_next = nie_pkg::ST_OK;
                    state_next = S_BS;
                end
            end

            S_BS:
            begin
                ram_raddr = AW'(mid_int);
                if (int'(hi_reg) - int'(idx_reg) > 1)
                begin
                    state_next = S_BSW;
                end
                else
                begin
                    s_int = (int'(idx_reg) >= int'(n_reg) / 2)
                          ? int'(idx_reg) - int'(n_reg) / 2 : 0;
                    if (s_int + int'(n_reg) + 1 > int'(count_reg))
                    begin
                        s_int = int'(count_reg) - int'(n_reg) - 1;
                    end
                    start_next = AW'(s_int);
                    state_next = S_LD_RD;
                end
            end

            S_BSW:
            begin
                if (rd_arg <= x_reg)
                begin
                    idx_next = CW'(mid_int);
                end
                else
                begin
                    hi_next = CW'(mid_int);
                end
                state_next = S_BS;
            end

            S_LD_RD:
            begin
                ram_raddr  = AW'(int'(start_reg) + int'(j_reg));
                state_next = S_LD_W;
            end

            S_LD_W:
            begin
                xs_next[j_reg]   = rd_arg;
                coef_next[j_reg] = rd_val;
                if (j_reg == n_reg)
                begin
                    if (n_reg == '0)
                    begin
                        done_next   = 1'b1;
                        result_next = rd_val;
                        status_next = qstat_reg;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        k_next     = DW'(1);
                        i_next     = n_reg;
                        state_next = S_DD;
                    end
                end
                else
                begin
                    j_next     = j_reg + DW'(1);
                    state_next = S_LD_RD;
                end
            end

            S_DD:
            begin
                alu_req.go = 1'b1;
                alu_req.op = nie_pkg::ALU_DIV;
                alu_req.a  = 33'(coef_reg[i_reg]) - 33'(coef_reg[i_reg - DW'(1)]);
                alu_req.b  = 33'(xs_reg[i_reg]) - 33'(xs_reg[i_reg - k_reg]);
                state_next = S_DD_WAIT;
            end

            S_DD_WAIT:
            begin
                if (alu_rsp.done)
                begin
                    coef_next[i_reg] = alu_rsp.value;
                    if (i_reg == k_reg)
                    begin
                        if (k_reg == n_reg)
                        begin
                            p_next     = alu_rsp.value;
                            state_next = S_HN;
                        end
                        else
                        begin
                            k_next     = k_reg + DW'(1);
                            i_next     = n_reg;
                            state_next = S_DD;
                        end
                    end
                    else
                    begin
                        i_next     = i_reg - DW'(1);
                        state_next = S_DD;
                    end
                end
            end

            S_HN:
            begin
                alu_req.go = 1'b1;
                alu_req.op = nie_pkg::ALU_MUL;
                alu_req.a  = 33'(x_reg) - 33'(xs_reg[k_reg - DW'(1)]);
                alu_req.b  = 33'(p_reg);
                alu_req.c  = coef_reg[k_reg - DW'(1)];
                state_next = S_HN_WAIT;
            end

            S_HN_WAIT:
            begin
                if (alu_rsp.done)
                begin
                    p_next = alu_rsp.value;
                    if (k_reg == DW'(1))
                    begin
                        done_next   = 1'b1;
                        result_next = alu_rsp.value;
                        status_next = qstat_reg;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg - DW'(1);
                        state_next = S_HN;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        hi_reg     <= hi_next;
        start_reg  <= start_next;
        j_reg      <= j_next;
        i_reg      <= i_next;
        k_reg      <= k_next;
        n_reg      <= n_next;
        x_reg      <= x_next;
        a_reg      <= a_next;
        v_reg      <= v_next;
        p_reg      <= p_next;
        qstat_reg  <= qstat_next;
        coef_reg   <= coef_next;
        xs_reg     <= xs_next;
        result_reg <= result_next;
        status_reg <= status_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign result_value = result_reg;
    assign status       = status_reg;

endmodule

// ===== src/nie_ram.sv =====
module nie_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/nie_alu.sv =====
// Serial unit: restoring divide of (a * 65536) / b, or shift-add multiply
// c + (a * b) / 65536; both truncate toward zero and saturate to 32 bits.
module nie_alu (
    input  logic              clk,
    input  logic              rst_n,
    input  nie_pkg::alu_req_t req,
    output nie_pkg::alu_rsp_t rsp
);

    logic               busy_reg, busy_next;
    nie_pkg::alu_op_t   op_reg, op_next;
    logic               neg_reg, neg_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic [33:0]        rem_reg, rem_next;
    logic [64:0]        sh_reg, sh_next;
    logic [64:0]        mc_reg, mc_next;
    logic [31:0]        mb_reg, mb_next;
    logic signed [31:0] c_reg, c_next;
    nie_pkg::alu_rsp_t  rsp_reg, rsp_next;

    logic [32:0]        abs_a, abs_b;
    logic [33:0]        rem_sh;
    logic               ge;
    logic [48:0]        q;
    logic signed [50:0] val, sum;

    always_comb
    begin
        abs_a     = req.a[32] ? 33'(-req.a) : 33'(req.a);
        abs_b     = req.b[32] ? 33'(-req.b) : 33'(req.b);
        rem_sh    = {rem_reg[32:0], sh_reg[48]};
        ge        = rem_sh >= {1'b0, mc_reg[32:0]};
        q         = (op_reg == nie_pkg::ALU_DIV) ? sh_reg[48:0] : sh_reg[64:16];
        val       = neg_reg ? -$signed({2'b00, q}) : $signed({2'b00, q});
        sum       = val + ((op_reg == nie_pkg::ALU_DIV) ? 51'sd0
                                                        : {{19{c_reg[31]}}, c_reg});
        busy_next = busy_reg;
        op_next   = op_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        mc_next   = mc_reg;
        mb_next   = mb_reg;
        c_next    = c_reg;
        rsp_next  = '{done: 1'b0, value: rsp_reg.value};

        if (req.go)
        begin
            op_next  = req.op;
            neg_next = req.a[32] ^ req.b[32];
            c_next   = req.c;
            rem_next = '0;
            mb_next  = abs_b[31:0];
            if (req.op == nie_pkg::ALU_DIV)
            begin
                sh_next  = {16'd0, abs_a, 16'd0};
                mc_next  = {32'd0, abs_b};
                cnt_next = 6'd49;
                if (req.b == '0)
                begin
                    // repeated node: saturate by the sign of the numerator
                    rsp_next.done  = 1'b1;
                    rsp_next.value = (req.a == '0) ? 32'sd0 :
                                     req.a[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
                    busy_next      = 1'b0;
                end
                else
                begin
                    busy_next = 1'b1;
                end
            end
            else
            begin
                sh_next   = '0;
                mc_next   = {32'd0, abs_a};
                cnt_next  = 6'd32;
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                cnt_next = cnt_reg - 6'd1;
                if (op_reg == nie_pkg::ALU_DIV)
                begin
                    rem_next = ge ? rem_sh - {1'b0, mc_reg[32:0]} : rem_sh;
                    sh_next  = {sh_reg[63:0], ge};
                end
                else
                begin
                    if (mb_reg[0])
                    begin
                        sh_next = sh_reg + mc_reg;
                    end
                    mc_next = {mc_reg[63:0], 1'b0};
                    mb_next = {1'b0, mb_reg[31:1]};
                end
            end
            else
            begin
                busy_next     = 1'b0;
                rsp_next.done = 1'b1;
                if (sum > 51'sd2147483647)
                begin
                    rsp_next.value = 32'sh7fff_ffff;
                end
                else if (sum < -51'sd2147483648)
                begin
                    rsp_next.value = 32'sh8000_0000;
                end
                else
                begin
                    rsp_next.value = sum[31:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            rsp_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            rsp_reg  <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        mc_reg  <= mc_next;
        mb_reg  <= mb_next;
        c_reg   <= c_next;
    end

    assign rsp = rsp_reg;

endmodule

// ===== test/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 32;
    localparam int MAXDEG = 7;
    localparam int ITEMS = 1200;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        int         value;
        logic [1:0] st;
    } interp_result_t;

    class interp_scoreboard;
        int             node_x [DEPTH];
        int             node_y [DEPTH];
        int             nodes;
        interp_result_t pending [$];
        int             errors;

        function new();
            nodes = 0;
            errors = 0;
        endfunction

        function longint clip32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint slope(longint num, longint den);
            if (den == 0) begin
                if (num > 0) return 64'sd2147483647;
                if (num < 0) return -64'sd2147483648;
                return 0;
            end
            return clip32((num * 65536) / den);
        endfunction

        function void note_beat(logic is_query, int arg, int val, int x, int deg);
            interp_result_t r;
            int     pos, first, lo, hi, mid, width;
            longint coef [MAXDEG+1];
            longint p, d;
            r.value = 0;
            if (!is_query) begin
                if (nodes >= DEPTH) begin
                    r.st = nie_pkg::ST_FULL;
                end else begin
                    pos = 0;
                    while (pos < nodes && node_x[pos] < arg) pos++;
                    for (int i = nodes; i > pos; i--) begin
                        node_x[i] = node_x[i-1];
                        node_y[i] = node_y[i-1];
                    end
                    node_x[pos] = arg;
                    node_y[pos] = val;
                    nodes++;
                    r.st = nie_pkg::ST_OK;
                end
                pending = {pending, r};
                return;
            end
            width = deg + 1;
            if (nodes < width) begin
                r.st = nie_pkg::ST_FEW;
                pending = {pending, r};
                return;
            end
            if (x <= node_x[0]) begin
                first = 0;
                r.st = nie_pkg::ST_EXTRAP;
            end else if (x >= node_x[nodes-1]) begin
                first = nodes - width;
                r.st = nie_pkg::ST_EXTRAP;
            end else begin
                lo = 0;
                hi = nodes - 1;
                while (hi - lo > 1) begin
                    mid = (lo + hi) / 2;
                    if (node_x[mid] <= x) lo = mid; else hi = mid;
                end
                first = (lo >= deg / 2) ? lo - deg / 2 : 0;
                if (first + width > nodes) first = nodes - width;
                r.st = nie_pkg::ST_OK;
            end
            for (int i = 0; i < width; i++) coef[i] = node_y[first+i];
            for (int k = 1; k < width; k++)
                for (int i = width - 1; i >= k; i--)
                    coef[i] = slope(coef[i] - coef[i-1],
                                    longint'(node_x[first+i]) - longint'(node_x[first+i-k]));
            p = coef[deg];
            for (int k = deg; k > 0; k--) begin
                d = longint'(x) - longint'(node_x[first+k-1]);
                p = clip32(coef[k-1] + (d * p) / 65536);
            end
            r.value = int'(p);
            pending = {pending, r};
        endfunction

        function void check_beat(int value, logic [1:0] st);
            interp_result_t e;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result value=%0d status=%0d", value, st);
                return;
            end
            e = pending.pop_front();
            if (e.value !== value || e.st !== st) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected value=%0d status=%0d, got value=%0d status=%0d",
                             e.value, e.st, value, st);
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               op = 1'b0;
    logic signed [31:0] node_arg = '0;
    logic signed [31:0] node_value = '0;
    logic signed [31:0] query_point = '0;
    logic [2:0]         degree = '0;
    logic               busy, done;
    logic signed [31:0] result_value;
    logic [1:0]         status;

    interp_scoreboard sb = new();
    int idle_pct = 0;
    int stall_cycles = 0;

    newton_interpolation_engine dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .op(op),
        .node_arg(node_arg), .node_value(node_value), .query_point(query_point),
        .degree(degree), .done(done), .result_value(result_value), .status(status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (done) sb.check_beat(result_value, status);
            if (done || (start && !busy)) stall_cycles = 0;
            else stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("testbench failed");
                $finish;
            end
        end
    end

    // hold the beat until accepted; start stays high into the next beat
    task automatic send_beat(logic is_query, int arg, int val, int x, int deg);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        op <= is_query;
        node_arg <= arg;
        node_value <= val;
        query_point <= x;
        degree <= deg;
        do @(posedge clk); while (busy);
        sb.note_beat(is_query, arg, val, x, deg);
    endtask

    function automatic int pick_arg();
        case ($urandom_range(3))
            0: return $urandom;
            1: return ($urandom_range(16) - 8) * 65536;
            default: return int'($urandom_range(32'h000F_FFFF)) - 32'sh0008_0000;
        endcase
    endfunction

    function automatic int pick_point();
        int j;
        if (sb.nodes == 0 || $urandom_range(4) == 0) return $urandom;
        j = $urandom_range(sb.nodes - 1);
        return sb.node_x[j] + int'($urandom_range(32'h3_FFFF)) - 32'sh2_0000;
    endfunction

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, then duplicates and extreme arguments and values
        send_beat(1'b1, 0, 0, 0, 0);
        send_beat(1'b0, 32'sh0001_0000, 32'sh0002_0000, 0, 0);
        send_beat(1'b1, 0, 0, 32'sh0001_0000, 1);
        send_beat(1'b1, 0, 0, 32'sh0001_0000, 0);
        send_beat(1'b0, 32'sh0001_0000, -32'sh0003_0000, 0, 0);
        send_beat(1'b1, 0, 0, 32'sh0000_8000, 1);
        send_beat(1'b0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0);
        send_beat(1'b0, 32'sh8000_0000, 32'sh8000_0000, 0, 0);
        send_beat(1'b0, 32'sh0003_0000, 0, 0, 0);
        send_beat(1'b0, -32'sh0002_0000, 32'sh0005_0000, 0, 0);
        send_beat(1'b0, 32'sh0005_0000, -1, 0, 0);
        send_beat(1'b0, 32'sh0002_0000, 32'sh7FFF_FFFF, 0, 0);
        send_beat(1'b1, 0, 0, 32'sh8000_0000, 7);
        send_beat(1'b1, 0, 0, 32'sh7FFF_FFFF, 7);
        send_beat(1'b1, 0, 0, 32'sh0002_8000, 7);
        send_beat(1'b1, 0, 0, 32'sh0001_0000, 2);
        send_beat(1'b1, 0, 0, 32'sh0004_0000, 3);
        send_beat(1'b1, 0, 0, -32'sh0001_0000, 4);

        for (int i = 0; i < ITEMS; i++) begin
            if (i == ITEMS / 3) idle_pct = 51;
            else if (i == 2 * ITEMS / 3) idle_pct = 0;
            else if (i == 0) idle_pct = 37;
            if ($urandom_range(99) < 30)
                send_beat(1'b0, pick_arg(), $urandom, $urandom, $urandom_range(7));
            else
                send_beat(1'b1, $urandom, $urandom, pick_point(), $urandom_range(7));
        end
        start <= 1'b0;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (sb.errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule

// ===== sim.f =====
src/nie_pkg.sv
src/nie_ram.sv
src/nie_alu.sv
src/newton_interpolation_engine.sv
test/testbench.sv
